>>> rtl/core/bqn_pkg.sv
package bqn_pkg;

   // channel and sample geometry
   localparam int CHANNELS    = 8;
   localparam int CHAN_BITS   = 3;
   localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SAMPLE_BITS = 24;

   // coefficients, signed Q2.22
   localparam int COEF_BITS  = 24;
   localparam int FRAC_SHIFT = 22;

   // arithmetic widths
   localparam int TAP_PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS      = TAP_PROD_BITS + 3;          // five products
   localparam int SCALED_BITS   = ACC_BITS - FRAC_SHIFT;      // rounded sum
   localparam int MUL_A_BITS    = SCALED_BITS;
   localparam int PROD_BITS     = MUL_A_BITS + COEF_BITS;
   localparam int Y_BITS        = PROD_BITS - FRAC_SHIFT;     // rounded, unsaturated

   // configuration registers
   localparam int NUM_REGS      = 6;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = COEF_BITS;

   localparam logic [CSR_ADDR_BITS-1:0] REG_FEED0 = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FEED1 = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FEED2 = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_BACK1 = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_BACK2 = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_GAIN  = 3'd5;

   localparam logic signed [COEF_BITS-1:0] COEF_ONE = 24'sh400000;

   // multiply-accumulate sequencing: one tap per step, one trailing step
   localparam int STEP_BITS = 3;
   localparam logic [STEP_BITS-1:0] STEP_X0   = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_X1   = 3'd1;
   localparam logic [STEP_BITS-1:0] STEP_X2   = 3'd2;
   localparam logic [STEP_BITS-1:0] STEP_Y1   = 3'd3;
   localparam logic [STEP_BITS-1:0] STEP_Y2   = 3'd4;
   localparam logic [STEP_BITS-1:0] STEP_LAST = 3'd5;

   typedef struct packed {
      logic                 load;     // item transfer: latch sample, clear acc
      logic                 mac;      // tap sequencing active
      logic [STEP_BITS-1:0] step;
      logic                 round;    // round acc into scaled
      logic                 finish;   // saturate, update history, load output
   } cmd_type;

endpackage

>>> rtl/core/bqn_if.sv
interface bqn_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [bqn_pkg::CHAN_BITS-1:0]           chan;
   logic signed [bqn_pkg::SAMPLE_BITS-1:0]  sample_in;

   modport source (output valid, output chan, output sample_in, input ready);
   modport sink   (input valid, input chan, input sample_in, output ready);
endinterface

interface bqn_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [bqn_pkg::CHAN_BITS-1:0]           chan_out;
   logic signed [bqn_pkg::SAMPLE_BITS-1:0]  sample_out;

   modport source (output valid, output chan_out, output sample_out, input ready);
   modport sink   (input valid, input chan_out, input sample_out, output ready);
endinterface

>>> rtl/core/bqn_datapath.sv
module bqn_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  bqn_pkg::cmd_type                         cmd,
   input  logic [bqn_pkg::CHAN_BITS-1:0]            req_chan,
   input  logic signed [bqn_pkg::SAMPLE_BITS-1:0]   req_sample,
   input  logic                                     csr_we,
   input  logic [bqn_pkg::CSR_ADDR_BITS-1:0]        csr_addr,
   input  logic [bqn_pkg::CSR_DATA_BITS-1:0]        csr_wdata,
   output logic [bqn_pkg::CHAN_BITS-1:0]            rsp_chan,
   output logic signed [bqn_pkg::SAMPLE_BITS-1:0]   rsp_sample
);

   localparam int SB = bqn_pkg::SAMPLE_BITS;
   localparam int EXT = bqn_pkg::MUL_A_BITS - SB;

   localparam logic signed [bqn_pkg::ACC_BITS-1:0] ACC_HALF =
      {{(bqn_pkg::ACC_BITS - bqn_pkg::FRAC_SHIFT){1'b0}}, 1'b1,
       {(bqn_pkg::FRAC_SHIFT-1){1'b0}}};
   localparam logic signed [bqn_pkg::PROD_BITS-1:0] PROD_HALF =
      {{(bqn_pkg::PROD_BITS - bqn_pkg::FRAC_SHIFT){1'b0}}, 1'b1,
       {(bqn_pkg::FRAC_SHIFT-1){1'b0}}};
   localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

   // coefficient registers
   logic signed [bqn_pkg::COEF_BITS-1:0] coef_ff [bqn_pkg::NUM_REGS];

   // per-channel history
   logic signed [SB-1:0] x1_ff [bqn_pkg::CHANNELS];
   logic signed [SB-1:0] x2_ff [bqn_pkg::CHANNELS];
   logic signed [SB-1:0] y1_ff [bqn_pkg::CHANNELS];
   logic signed [SB-1:0] y2_ff [bqn_pkg::CHANNELS];

   // working registers
   logic [bqn_pkg::CHAN_BITS-1:0]             chan_ff;
   logic signed [SB-1:0]                      x_ff;
   logic signed [bqn_pkg::PROD_BITS-1:0]      prod_ff, prod_in;
   logic signed [bqn_pkg::ACC_BITS-1:0]       acc_ff, acc_in;
   logic signed [bqn_pkg::SCALED_BITS-1:0]    scaled_ff;
   logic [bqn_pkg::CHAN_BITS-1:0]             rsp_chan_ff;
   logic signed [SB-1:0]                      rsp_sample_ff;

   logic [bqn_pkg::CH_IDX_BITS-1:0]           idx;
   logic signed [SB-1:0]                      tap_sample;
   logic signed [bqn_pkg::MUL_A_BITS-1:0]     mul_a;
   logic signed [bqn_pkg::COEF_BITS-1:0]      mul_b;
   logic [bqn_pkg::STEP_BITS-1:0]             prod_step;
   logic                                      acc_sub;
   logic signed [bqn_pkg::ACC_BITS-1:0]       acc_rnd;
   logic signed [bqn_pkg::PROD_BITS-1:0]      y_rnd;
   logic signed [bqn_pkg::Y_BITS-1:0]         y_full;
   logic [bqn_pkg::Y_BITS-SB:0]               y_top;
   logic signed [SB-1:0]                      y_sat;

   assign idx = chan_ff[bqn_pkg::CH_IDX_BITS-1:0];

   // tap operand select
   always_comb begin
      case (cmd.step)
         bqn_pkg::STEP_X0: tap_sample = x_ff;
         bqn_pkg::STEP_X1: tap_sample = x1_ff[idx];
         bqn_pkg::STEP_X2: tap_sample = x2_ff[idx];
         bqn_pkg::STEP_Y1: tap_sample = y1_ff[idx];
         bqn_pkg::STEP_Y2: tap_sample = y2_ff[idx];
         default:          tap_sample = '0;
      endcase
   end

   // shared multiplier: taps while sequencing, gain otherwise
   always_comb begin
      if (cmd.mac) begin
         mul_a = {{EXT{tap_sample[SB-1]}}, tap_sample};
         mul_b = coef_ff[cmd.step];
      end else begin
         mul_a = scaled_ff;
         mul_b = coef_ff[bqn_pkg::REG_GAIN];
      end
      prod_in = mul_a * mul_b;
   end

   // product registered last step; feedback taps subtract
   assign prod_step = cmd.step - 3'd1;
   assign acc_sub   = (prod_step == bqn_pkg::STEP_Y1) || (prod_step == bqn_pkg::STEP_Y2);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = '0;
      end else if (cmd.mac && (cmd.step != bqn_pkg::STEP_X0)) begin
         if (acc_sub) begin
            acc_in = acc_ff - $signed(prod_ff[bqn_pkg::ACC_BITS-1:0]);
         end else begin
            acc_in = acc_ff + $signed(prod_ff[bqn_pkg::ACC_BITS-1:0]);
         end
      end
   end

   // round half up, floor shift
   assign acc_rnd = acc_ff + ACC_HALF;
   assign y_rnd   = prod_ff + PROD_HALF;
   assign y_full  = y_rnd[bqn_pkg::PROD_BITS-1:bqn_pkg::FRAC_SHIFT];
   assign y_top   = y_full[bqn_pkg::Y_BITS-1:SB-1];

   always_comb begin
      if ((&y_top) || !(|y_top)) begin
         y_sat = y_full[SB-1:0];
      end else if (y_full[bqn_pkg::Y_BITS-1]) begin
         y_sat = SAMPLE_MIN;
      end else begin
         y_sat = SAMPLE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[bqn_pkg::REG_FEED0] <= bqn_pkg::COEF_ONE;
         coef_ff[bqn_pkg::REG_FEED1] <= '0;
         coef_ff[bqn_pkg::REG_FEED2] <= '0;
         coef_ff[bqn_pkg::REG_BACK1] <= '0;
         coef_ff[bqn_pkg::REG_BACK2] <= '0;
         coef_ff[bqn_pkg::REG_GAIN]  <= bqn_pkg::COEF_ONE;
      end else if (csr_we && (csr_addr < bqn_pkg::CSR_ADDR_BITS'(bqn_pkg::NUM_REGS))) begin
         coef_ff[csr_addr] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bqn_pkg::CHANNELS; i++) begin
            x1_ff[i] <= '0;
            x2_ff[i] <= '0;
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else if (cmd.finish) begin
         x2_ff[idx] <= x1_ff[idx];
         x1_ff[idx] <= x_ff;
         y2_ff[idx] <= y1_ff[idx];
         y1_ff[idx] <= y_sat;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.load) begin
         chan_ff <= req_chan;
         x_ff    <= req_sample;
      end
      if (cmd.round) begin
         scaled_ff <= acc_rnd[bqn_pkg::ACC_BITS-1:bqn_pkg::FRAC_SHIFT];
      end
      if (cmd.finish) begin
         rsp_chan_ff   <= chan_ff;
         rsp_sample_ff <= y_sat;
      end
   end

   assign rsp_chan   = rsp_chan_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

>>> rtl/core/bqn_ctrl.sv
module bqn_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bqn_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAC   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_GAIN  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]                      state_ff, state_in;
   logic [bqn_pkg::STEP_BITS-1:0]   step_ff, step_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            out_free;
   logic                            accept;
   logic                            finish;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_OUT) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || finish;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MAC;
               step_in  = bqn_pkg::STEP_X0;
            end
         end
         ST_MAC: begin
            if (step_ff == bqn_pkg::STEP_LAST) begin
               state_in = ST_ROUND;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_ROUND: state_in = ST_GAIN;
         ST_GAIN:  state_in = ST_OUT;
         ST_OUT: begin
            if (finish) begin
               if (accept) begin
                  state_in = ST_MAC;
                  step_in  = bqn_pkg::STEP_X0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= bqn_pkg::STEP_X0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = accept;
   assign cmd.mac    = (state_ff == ST_MAC);
   assign cmd.step   = step_ff;
   assign cmd.round  = (state_ff == ST_ROUND);
   assign cmd.finish = finish;

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_accept_state: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == ST_IDLE || state_ff == ST_OUT))
      else $error("item taken while busy");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MAC && step_ff == bqn_pkg::STEP_X0))
      else $error("tap sequence did not start after transfer");

   a_gain_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAIN) |-> ($past(state_ff) == ST_ROUND))
      else $error("gain step without rounded sum");

endmodule

>>> rtl/core/biquad_notch_filter.sv
// Channel  Dir  Handshake           Payload
// req_ch   in   valid/ready         chan[2:0], sample_in[23:0] (Q1.23)
// rsp_ch   out  valid/ready         chan_out[2:0], sample_out[23:0] (Q1.23)
// csr      in   csr_we, no stall    csr_addr[2:0], csr_wdata[23:0] (Q2.22)
//
// An item runs on the single shared multiplier from transfer to result in order:
// five tap products, one trailing accumulate, round, gain, output.
// A new item is taken in the cycle its predecessor's result is loaded, so the
// block does not start a new item while the last one is still being processed.
// Reset (synchronous, active high) clears history and loads default coefficients.
// A result waits in the output register; a stall holds only the final step.
module biquad_notch_filter (
   input  logic                                clock,
   input  logic                                reset,
   bqn_req_if.sink                             req_ch,
   bqn_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [bqn_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [bqn_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   bqn_pkg::cmd_type cmd;

   // sequencer: tap steps, round, gain, output load
   bqn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // multiply-accumulate, coefficient registers, per-channel history
   bqn_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_chan   (req_ch.chan),
      .req_sample (req_ch.sample_in),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_chan   (rsp_ch.chan_out),
      .rsp_sample (rsp_ch.sample_out)
   );

endmodule

>>> dv/biquad_notch_filter_tb.sv
module biquad_notch_filter_tb;
   import bqn_pkg::*;

   // ------------------------------------------------------------------
   // Run limits
   // ------------------------------------------------------------------
   localparam int ITEMS_PER_PHASE = 100;   // eight coefficient phases
   localparam int MAX_WAIT        = 13;    // per-item idle draw, either side
   localparam int HOLD_CYCLES     = 300;   // long rsp hold-off, fills the block
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any transfer
   localparam int TAIL_CYCLES     = 30;    // quiet time after the last result

   // Spare CSR indexes past the coefficient bank; writes there are dropped.
   localparam logic [CSR_ADDR_BITS-1:0] REG_SPARE_LO = CSR_ADDR_BITS'(NUM_REGS);
   localparam logic [CSR_ADDR_BITS-1:0] REG_SPARE_HI = CSR_ADDR_BITS'(NUM_REGS + 1);

   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam longint ROUND_HALF = longint'(1) <<< (FRAC_SHIFT - 1);

   localparam logic [SAMPLE_BITS-1:0] X_MAX = SAMPLE_BITS'(SAMPLE_MAX);
   localparam logic [SAMPLE_BITS-1:0] X_MIN = SAMPLE_BITS'(SAMPLE_MIN);
   localparam logic [COEF_BITS-1:0]   C_MAX = 24'h7FFFFF;
   localparam logic [COEF_BITS-1:0]   C_MIN = 24'h800000;

   // Notch near 0.05*fs, Q about 5; a0 folded into the gain register.
   localparam logic signed [COEF_BITS-1:0] NOTCH_B1   = -24'sd7977567;
   localparam logic signed [COEF_BITS-1:0] NOTCH_A2   = 24'sd4064281;
   localparam logic signed [COEF_BITS-1:0] NOTCH_GAIN = 24'sd4068474;

   // ------------------------------------------------------------------
   // Directed plan: CSR writes, rows with a hand-read answer, and rows
   // left to the filter model.
   // ------------------------------------------------------------------
   typedef enum logic [1:0] {ROW_CSR, ROW_FIXED, ROW_MODEL} row_kind_e;

   typedef struct packed {
      row_kind_e              kind;
      logic [2:0]             sel;    // CSR index or channel
      logic [COEF_BITS-1:0]   data;   // write data or sample
      logic [SAMPLE_BITS-1:0] want;   // ROW_FIXED only
   } dir_row_t;

   typedef enum int {
      STYLE_NOTCH, STYLE_NOTCH_GAIN, STYLE_RANDOM, STYLE_ALL_MAX,
      STYLE_ALL_MIN, STYLE_MILD, STYLE_IDENTITY
   } coef_style_e;

   typedef struct {
      logic [CHAN_BITS-1:0]          chan;
      logic signed [SAMPLE_BITS-1:0] sample;
   } filt_out_t;

   dir_row_t directed_plan [$] = '{
      // reset coefficients pass the sample through untouched
      '{ROW_FIXED, 3'd0, X_MAX,     X_MAX},
      '{ROW_FIXED, 3'd1, X_MIN,     X_MIN},
      '{ROW_FIXED, 3'd2, 24'h000000, 24'h000000},
      '{ROW_FIXED, 3'd7, 24'hFFFFFF, 24'hFFFFFF},
      '{ROW_FIXED, 3'd3, 24'h000001, 24'h000001},
      '{ROW_FIXED, 3'd4, 24'h555555, 24'h555555},
      '{ROW_FIXED, 3'd5, 24'hAAAAAA, 24'hAAAAAA},
      '{ROW_FIXED, 3'd6, 24'h123456, 24'h123456},
      // writes past the register bank must not disturb anything
      '{ROW_CSR,   REG_SPARE_LO, 24'hABCDEF, 24'h0},
      '{ROW_CSR,   REG_SPARE_HI, C_MAX,      24'h0},
      '{ROW_FIXED, 3'd0, 24'h000100, 24'h000100},
      // gain near 4.0 overall: full-scale input clips both ways
      '{ROW_CSR,   REG_FEED0, C_MAX, 24'h0},
      '{ROW_CSR,   REG_GAIN,  C_MAX, 24'h0},
      '{ROW_FIXED, 3'd1, X_MAX,      X_MAX},
      '{ROW_FIXED, 3'd2, X_MIN,      X_MIN},
      '{ROW_FIXED, 3'd3, 24'h000000, 24'h000000},
      // real notch, a step on ch4 with ch5 interleaved
      '{ROW_CSR,   REG_FEED0, COEF_ONE,   24'h0},
      '{ROW_CSR,   REG_FEED1, NOTCH_B1,   24'h0},
      '{ROW_CSR,   REG_FEED2, COEF_ONE,   24'h0},
      '{ROW_CSR,   REG_BACK1, NOTCH_B1,   24'h0},
      '{ROW_CSR,   REG_BACK2, NOTCH_A2,   24'h0},
      '{ROW_CSR,   REG_GAIN,  NOTCH_GAIN, 24'h0},
      '{ROW_MODEL, 3'd4, 24'h200000, 24'h0},
      '{ROW_MODEL, 3'd4, 24'h200000, 24'h0},
      '{ROW_MODEL, 3'd5, 24'hE00000, 24'h0},
      '{ROW_MODEL, 3'd4, 24'h200000, 24'h0},
      '{ROW_MODEL, 3'd4, 24'h000000, 24'h0},
      '{ROW_MODEL, 3'd5, 24'h000000, 24'h0},
      // every coefficient at its most negative value
      '{ROW_CSR,   REG_FEED0, C_MIN, 24'h0},
      '{ROW_CSR,   REG_FEED1, C_MIN, 24'h0},
      '{ROW_CSR,   REG_FEED2, C_MIN, 24'h0},
      '{ROW_CSR,   REG_BACK1, C_MIN, 24'h0},
      '{ROW_CSR,   REG_BACK2, C_MIN, 24'h0},
      '{ROW_CSR,   REG_GAIN,  C_MIN, 24'h0},
      '{ROW_MODEL, 3'd6, X_MAX,      24'h0},
      '{ROW_MODEL, 3'd6, X_MIN,      24'h0},
      '{ROW_MODEL, 3'd7, X_MAX,      24'h0},
      '{ROW_MODEL, 3'd6, 24'h000000, 24'h0},
      // and at its most positive
      '{ROW_CSR,   REG_FEED0, C_MAX, 24'h0},
      '{ROW_CSR,   REG_FEED1, C_MAX, 24'h0},
      '{ROW_CSR,   REG_FEED2, C_MAX, 24'h0},
      '{ROW_CSR,   REG_BACK1, C_MAX, 24'h0},
      '{ROW_CSR,   REG_BACK2, C_MAX, 24'h0},
      '{ROW_CSR,   REG_GAIN,  C_MAX, 24'h0},
      '{ROW_MODEL, 3'd0, X_MAX,      24'h0},
      '{ROW_MODEL, 3'd0, X_MIN,      24'h0}
   };

   coef_style_e phase_plan [8] = '{
      STYLE_NOTCH, STYLE_RANDOM, STYLE_ALL_MAX, STYLE_ALL_MIN,
      STYLE_MILD, STYLE_IDENTITY, STYLE_RANDOM, STYLE_NOTCH_GAIN
   };

   // ------------------------------------------------------------------
   // DUT and its channels
   // ------------------------------------------------------------------
   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_ADDR_BITS-1:0]   csr_addr;
   logic [CSR_DATA_BITS-1:0]   csr_wdata;

   bqn_req_if req_ch ();
   bqn_rsp_if rsp_ch ();

   biquad_notch_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Filter model state: coefficients plus per-channel x/y history
   // ------------------------------------------------------------------
   logic signed [COEF_BITS-1:0]   coef    [NUM_REGS];
   logic signed [SAMPLE_BITS-1:0] x_hist1 [CHANNELS] = '{default: '0};
   logic signed [SAMPLE_BITS-1:0] x_hist2 [CHANNELS] = '{default: '0};
   logic signed [SAMPLE_BITS-1:0] y_hist1 [CHANNELS] = '{default: '0};
   logic signed [SAMPLE_BITS-1:0] y_hist2 [CHANNELS] = '{default: '0};

   filt_out_t filtered_q [$];     // outputs owed by the DUT, oldest first

   int  errors      = 0;
   int  sent        = 0;
   int  checked     = 0;
   int  clipped     = 0;
   int  coef_sets   = 0;
   int  stall_cycles = 0;
   int  req_quiet   = 0;          // items left in a no-gap burst, sender
   bit  hold_rsp    = 1'b0;       // asks the receiver for one long hold-off

   // DF-I biquad: exact sum, round to sample precision, scale by gain,
   // round again, clip. Updates the channel's history as the DUT does.
   function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
      input logic [CHAN_BITS-1:0]          chan,
      input logic signed [SAMPLE_BITS-1:0] x
   );
      int     c;
      longint acc;
      longint scaled;
      longint y;
      c = int'(chan) % CHANNELS;
      acc = longint'(coef[REG_FEED0]) * longint'(x)
          + longint'(coef[REG_FEED1]) * longint'(x_hist1[c])
          + longint'(coef[REG_FEED2]) * longint'(x_hist2[c])
          - longint'(coef[REG_BACK1]) * longint'(y_hist1[c])
          - longint'(coef[REG_BACK2]) * longint'(y_hist2[c]);
      scaled = (acc + ROUND_HALF) >>> FRAC_SHIFT;
      y = (scaled * longint'(coef[REG_GAIN]) + ROUND_HALF) >>> FRAC_SHIFT;
      if (y > SAMPLE_MAX) begin
         y = SAMPLE_MAX;
         clipped++;
      end else if (y < SAMPLE_MIN) begin
         y = SAMPLE_MIN;
         clipped++;
      end
      x_hist2[c] = x_hist1[c];
      x_hist1[c] = x;
      y_hist2[c] = y_hist1[c];
      y_hist1[c] = SAMPLE_BITS'(y);   // clipped value is what feeds back
      return SAMPLE_BITS'(y);
   endfunction

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Watchdog: any run of cycles with no transfer on either side
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a transfer, %0d outputs owed",
                  stall_cycles, filtered_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------

   // Offer one sample after a random gap; on transfer, run the model and
   // queue what the DUT owes. Valid is left high so a zero gap streams.
   task automatic push_sample(
      input logic [CHAN_BITS-1:0]   chan,
      input logic [SAMPLE_BITS-1:0] x,
      input bit                     use_fixed,
      input logic [SAMPLE_BITS-1:0] fixed_y
   );
      int        gap;
      filt_out_t owed;
      if (req_quiet > 0) begin
         gap = 0;
         req_quiet--;
      end else if ($urandom_range(0, 19) == 0) begin
         gap = 0;
         req_quiet = $urandom_range(10, 40);
      end else begin
         gap = $urandom_range(0, MAX_WAIT);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.chan      <= chan;
      req_ch.sample_in <= x;
      do @(posedge clock); while (!req_ch.ready);
      // transfer at this edge
      owed.chan   = chan;
      owed.sample = filter_sample(chan, x);
      if (use_fixed) owed.sample = fixed_y;
      filtered_q.push_back(owed);
      sent++;
   endtask

   // Stop offering and wait until every owed output has come back, so the
   // DUT is idle for a coefficient change.
   task automatic drain;
      req_ch.valid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
   endtask

   // One CSR write; the caller drops csr_we after the last of a burst.
   task automatic write_reg(
      input logic [CSR_ADDR_BITS-1:0] idx,
      input logic [CSR_DATA_BITS-1:0] val
   );
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx < NUM_REGS) coef[idx] = val;
   endtask

   task automatic program_coefs(input coef_style_e style);
      logic [CSR_DATA_BITS-1:0] val [NUM_REGS];
      int                       r;
      for (r = 0; r < NUM_REGS; r++) val[r] = '0;
      case (style)
         STYLE_NOTCH, STYLE_NOTCH_GAIN: begin
            val[REG_FEED0] = COEF_ONE;
            val[REG_FEED1] = NOTCH_B1;
            val[REG_FEED2] = COEF_ONE;
            val[REG_BACK1] = NOTCH_B1;
            val[REG_BACK2] = NOTCH_A2;
            val[REG_GAIN]  = (style == STYLE_NOTCH_GAIN) ? CSR_DATA_BITS'($urandom)
                                                         : NOTCH_GAIN;
         end
         STYLE_RANDOM: begin
            for (r = 0; r < NUM_REGS; r++) val[r] = CSR_DATA_BITS'($urandom);
         end
         STYLE_ALL_MAX: begin
            for (r = 0; r < NUM_REGS; r++) val[r] = C_MAX;
         end
         STYLE_ALL_MIN: begin
            for (r = 0; r < NUM_REGS; r++) val[r] = C_MIN;
         end
         STYLE_MILD: begin
            // within +-1.0, keeps most outputs off the rails
            for (r = 0; r < NUM_REGS; r++)
               val[r] = CSR_DATA_BITS'(int'($urandom_range(0, 2 * int'(COEF_ONE)))
                                       - int'(COEF_ONE));
         end
         default: begin
            val[REG_FEED0] = COEF_ONE;
            val[REG_GAIN]  = COEF_ONE;
         end
      endcase
      for (r = 0; r < NUM_REGS; r++) write_reg(CSR_ADDR_BITS'(r), val[r]);
      if ($urandom_range(0, 1) == 1)
         write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO,
                   CSR_DATA_BITS'($urandom));
      csr_we <= 1'b0;
      coef_sets++;
   endtask

   // ------------------------------------------------------------------
   // Receiver side: random ready gaps, one long hold-off on request,
   // every output transfer checked against the oldest owed one.
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int        gap;
      int        quiet;
      filt_out_t want;
      quiet = 0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            gap      = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else if (quiet > 0) begin
            gap = 0;
            quiet--;
         end else if ($urandom_range(0, 19) == 0) begin
            gap   = 0;
            quiet = $urandom_range(10, 40);
         end else begin
            gap = $urandom_range(0, MAX_WAIT);
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         // transfer at this edge
         if (filtered_q.size() == 0) begin
            $error("unexpected output: chan_out %0d sample_out %0d",
                   rsp_ch.chan_out, rsp_ch.sample_out);
            errors++;
         end else begin
            want = filtered_q.pop_front();
            checked++;
            if (rsp_ch.chan_out !== want.chan) begin
               $error("chan_out: expected %0d, got %0d", want.chan, rsp_ch.chan_out);
               errors++;
            end
            if (rsp_ch.sample_out !== want.sample) begin
               $error("sample_out: expected %0d, got %0d", want.sample, rsp_ch.sample_out);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      dir_row_t               row;
      int                     i;
      int                     phase;
      int                     n;
      int                     pick;
      logic [CHAN_BITS-1:0]   chan;
      logic [SAMPLE_BITS-1:0] x;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.chan      <= '0;
      req_ch.sample_in <= '0;
      csr_we           <= 1'b0;
      csr_addr         <= '0;
      csr_wdata        <= '0;
      for (i = 0; i < NUM_REGS; i++) coef[i] = '0;
      coef[REG_FEED0] = COEF_ONE;
      coef[REG_GAIN]  = COEF_ONE;
      chan = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; a CSR burst waits for the DUT to go idle first
      for (i = 0; i < directed_plan.size(); i++) begin
         row = directed_plan[i];
         if (row.kind == ROW_CSR) begin
            if (i == 0 || directed_plan[i-1].kind != ROW_CSR) drain();
            write_reg(row.sel, row.data);
            if (i + 1 == directed_plan.size() || directed_plan[i+1].kind != ROW_CSR) begin
               csr_we <= 1'b0;
               coef_sets++;
            end
         end else begin
            push_sample(row.sel, row.data, row.kind == ROW_FIXED, row.want);
         end
      end

      // random phases, one coefficient set each
      for (phase = 0; phase < $size(phase_plan); phase++) begin
         drain();
         program_coefs(phase_plan[phase]);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // back-pressure once mid-run while the sender keeps offering
            if (phase == 4 && n == 20) hold_rsp = 1'b1;
            // channel often repeats so the history gets a workout
            if ($urandom_range(0, 2) != 0) chan = CHAN_BITS'($urandom_range(0, 7));
            pick = $urandom_range(0, 9);
            if (pick == 0)      x = X_MAX;
            else if (pick == 1) x = X_MIN;
            else if (pick == 2) x = SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
            else                x = SAMPLE_BITS'($urandom);
            push_sample(chan, x, 1'b0, '0);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("summary: %0d samples in, %0d outputs checked, %0d clipped",
               sent, checked, clipped);
      $display("summary: %0d coefficient sets, %0d errors", coef_sets, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
